FILE: rtl/core/ipv4dq_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types and constants shared by the dotted-quad IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  // Character codes and limits
  localparam logic [7:0] DotChar    = 8'h2E;
  localparam logic [7:0] DigitZero  = 8'h30;
  localparam logic [7:0] DigitNine  = 8'h39;
  localparam logic [8:0] OctetLimit = 9'd256;

  // Result status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadChar  = 2'd1,
    StOverflow = 2'd2
  } status_e;

  // One input item: a character and its start-of-string flag
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] address;
    status_e     status;
  } out_item_t;

endpackage

FILE: rtl/core/ipv4_dotted_quad_parser_top.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_top
// Character-serial dotted-decimal IPv4 address parser.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per cycle, with first marking the start
// of a string and the terminating NUL sent as an ordinary character. Each
// string yields exactly one result: the 32-bit address with status ok, or a
// zero address with status bad character or octet above 255. Characters after
// a result, and all characters before the first start flag after reset, are
// dropped. Throughput is one character per cycle: the parse state is updated
// in the cycle the character is taken, and a result sits in the output
// register in the cycle after. The input stalls only while the output
// register holds a result that the receiver is stalling.
module ipv4_dotted_quad_parser_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ipv4dq_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ipv4dq_pkg::out_item_t out_item_o
);
  import ipv4dq_pkg::*;

  // Parse state
  logic [1:0]  field_index_q, field_index_d;
  logic [8:0]  octet_accum_q, octet_accum_d;
  logic [23:0] partial_q, partial_d;
  logic        finished_q, finished_d;

  // Output register
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic        in_accept;
  logic        res_valid;
  out_item_t   res_item;

  // Start-of-string view of the state
  logic [1:0]  fi_eff;
  logic [8:0]  acc_eff;
  logic [23:0] pv_eff;
  logic        fin_eff;
  logic        is_digit;
  logic [11:0] acc_next;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Parse step
  always_comb begin
    fi_eff   = in_item_i.first ? 2'd0  : field_index_q;
    acc_eff  = in_item_i.first ? 9'd0  : octet_accum_q;
    pv_eff   = in_item_i.first ? 24'd0 : partial_q;
    fin_eff  = in_item_i.first ? 1'b0  : finished_q;
    is_digit = in_item_i.ch inside {[DigitZero:DigitNine]};
    // acc * 10 + digit, acc is at most 256
    acc_next = {acc_eff, 3'b000} + {2'b00, acc_eff, 1'b0}
             + {8'd0, in_item_i.ch[3:0]};

    field_index_d    = fi_eff;
    octet_accum_d    = acc_eff;
    partial_d        = pv_eff;
    finished_d       = fin_eff;
    res_valid        = 1'b0;
    res_item.address = '0;
    res_item.status  = StOk;

    if (!fin_eff) begin
      if (is_digit) begin
        octet_accum_d = (acc_next > {3'b000, OctetLimit}) ? OctetLimit : acc_next[8:0];
      end else if (fi_eff != 2'd3 && in_item_i.ch != DotChar) begin
        res_valid       = 1'b1;
        res_item.status = StBadChar;
        finished_d      = 1'b1;
      end else if (acc_eff >= OctetLimit) begin
        res_valid       = 1'b1;
        res_item.status = StOverflow;
        finished_d      = 1'b1;
      end else if (fi_eff == 2'd3) begin
        res_valid        = 1'b1;
        res_item.address = {pv_eff, acc_eff[7:0]};
        finished_d       = 1'b1;
      end else begin
        // end of fields 0 to 2
        partial_d     = {pv_eff[15:0], acc_eff[7:0]};
        field_index_d = fi_eff + 2'd1;
        octet_accum_d = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_index_q <= '0;
      octet_accum_q <= '0;
      partial_q     <= '0;
      finished_q    <= 1'b1;
    end else if (in_accept) begin
      field_index_q <= field_index_d;
      octet_accum_q <= octet_accum_d;
      partial_q     <= partial_d;
      finished_q    <= finished_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // An error result always carries a zero address
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.status != StOk |-> out_item_q.address == '0)
    else $error("error result with nonzero address");

  // A result closes the parse until the next start flag
  a_result_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && res_valid |=> finished_q && out_valid_q)
    else $error("result did not close the parse");

  // The accumulator never exceeds its saturation value
  a_accum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finished_q |-> octet_accum_q <= OctetLimit)
    else $error("octet accumulator above saturation");
`endif

endmodule

FILE: dv/ipv4_dotted_quad_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_checker
// Watches both channels of the dotted-quad parser and checks its results.
// Each character taken by the block is run through a local copy of the
// parse state. A finished parse queues the address or error it must give.
// Each result taken from the block is compared field by field with the
// oldest queued address.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  ipv4dq_pkg::in_item_t  in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  ipv4dq_pkg::out_item_t out_item_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  import ipv4dq_pkg::*;

  localparam int unsigned Radix = 10;

  // Parse state
  logic [1:0]  field_idx;
  logic [8:0]  octet_acc;
  logic [23:0] done_octets;
  logic        awaiting_first;

  out_item_t   addr_q[$];
  int          err_count = 0;

  assign fail_count_o = err_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic finish_parse(input logic [31:0] addr, input status_e st);
    out_item_t res;
    res.address = addr;
    res.status  = st;
    addr_q.push_back(res);
    awaiting_first = 1'b1;
  endtask

  // One character through the parser
  task automatic parse_char(input in_item_t it);
    int unsigned sum;
    if (it.first) begin
      field_idx      = '0;
      octet_acc      = '0;
      done_octets    = '0;
      awaiting_first = 1'b0;
    end
    if (!awaiting_first) begin
      if (it.ch >= DigitZero && it.ch <= DigitNine) begin
        // accumulate, saturating at the octet limit
        sum = octet_acc * Radix + (it.ch - DigitZero);
        octet_acc = (sum > OctetLimit) ? OctetLimit : 9'(sum);
      end else if (field_idx != 2'd3 && it.ch != DotChar) begin
        finish_parse('0, StBadChar);
      end else if (octet_acc >= OctetLimit) begin
        finish_parse('0, StOverflow);
      end else if (field_idx == 2'd3) begin
        finish_parse({done_octets, octet_acc[7:0]}, StOk);
      end else begin
        // dot closes fields 0 to 2
        done_octets = {done_octets[15:0], octet_acc[7:0]};
        field_idx++;
        octet_acc = '0;
      end
    end
  endtask

  // Results first, then the character taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      field_idx      = '0;
      octet_acc      = '0;
      done_octets    = '0;
      awaiting_first = 1'b1;
      addr_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (addr_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result addr %h st %0d",
                                    out_item_i.address, out_item_i.status));
        end else begin
          want = addr_q.pop_front();
          if (out_item_i.address !== want.address)
            report_mismatch($sformatf("address got %h want %h",
                                      out_item_i.address, want.address));
          if (out_item_i.status !== want.status)
            report_mismatch($sformatf("st got %0d want %0d",
                                      out_item_i.status, want.status));
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(in_item_i);
      pending_o <= addr_q.size();
    end
  end

endmodule

FILE: dv/tb_ipv4_dotted_quad_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_quad_parser_top
// Stimulus and verdict for the dotted-quad IPv4 address parser.
// A short directed list covers octet extremes, empty fields, overflow, bad
// characters and ignored characters. Then random address strings follow,
// mostly well formed with random octets and terminators, some corrupted,
// cut short or pure noise. Both sides idle and stall at random. The checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_quad_parser_top;
  import ipv4dq_pkg::*;

  localparam int          NumRandomChars = 1150;
  localparam logic [7:0]  NulChar        = 8'h00;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  in_item_t   char_q[$];
  logic [7:0] word_q[$];

  ipv4_dotted_quad_parser_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  ipv4_dotted_quad_parser_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  task automatic add_char(input logic [7:0] c, input logic f);
    in_item_t it;
    it.ch    = c;
    it.first = f;
    char_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == 0);
  endtask

  // One octet field: empty, plain, extreme, leading zeros or too large
  task automatic add_field();
    int unsigned pick;
    int unsigned zeros;
    int unsigned value;
    string       digits;
    pick = $urandom_range(0, 99);
    if (pick >= 8) begin
      zeros = (pick < 16) ? $urandom_range(1, 3) : 0;
      repeat (zeros) word_q.push_back(DigitZero);
      if (pick < 21)      value = $urandom_range(256, 999);
      else if (pick < 26) value = $urandom_range(1000, 99999);
      else if (pick < 30) value = 255;
      else if (pick < 34) value = 0;
      else                value = $urandom_range(0, 255);
      digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) word_q.push_back(digits[i]);
    end
  endtask

  // One address string, then a little trailing junk
  task automatic add_address();
    int unsigned kind;
    int unsigned trim;
    logic [7:0]  term;
    word_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // pure noise
      repeat ($urandom_range(1, 12)) word_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int f = 0; f < 4; f++) begin
        add_field();
        if (f < 3) word_q.push_back(DotChar);
      end
      term = 8'($urandom_range(0, 255));
      if (term >= DigitZero && term <= DigitNine) term = DotChar;
      if (kind < 60)      word_q.push_back(NulChar);
      else if (kind < 80) word_q.push_back(term);
      else                word_q.push_back(DotChar);
      // corrupt one character
      if (kind >= 88)
        word_q[$urandom_range(0, word_q.size() - 1)] = 8'($urandom_range(0, 255));
      // cut short, the next string restarts the parse
      if (kind >= 95) begin
        trim = $urandom_range(1, word_q.size() - 1);
        repeat (trim) word_q.delete(word_q.size() - 1);
      end
    end
    foreach (word_q[i]) add_char(word_q[i], i == 0);
    repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Sender: directed list, random strings, then wait for the last result
  initial begin : send_chars
    int unsigned gap;
    add_char(8'h78, 1'b0);        // before any start flag, dropped
    add_text("255.0..7");         // top octet, empty field
    add_char(8'hFF, 1'b0);        // high character ends the last field
    add_char(8'h31, 1'b0);        // after a result, dropped
    add_text("999.");             // octet overflow
    add_text("12");               // restarted mid string
    add_text("1x");               // bad character
    add_text("....");             // all fields empty, dot ends the last
    add_char(NulChar, 1'b1);      // terminator in the first field
    while (char_q.size() < NumRandomChars) add_address();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (char_q[i]) begin
      gap = (((i / 64) % 4) == 2) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= char_q[i];
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls, free-running stretches, two long holds
  initial begin : take_results
    int unsigned hold;
    int          taken;
    taken = 0;
    forever begin
      if (taken == 40 || taken == 150) hold = 80;
      else if (((taken / 16) % 4) == 1) hold = 0;
      else hold = $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Run limit
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
